FILE: rtl/core/x86tlb_pkg.sv
// ----------------------------------------------------------------------------
// x86tlb_pkg
// Shared types, codes and helpers of the paging unit and its TLB.
// ----------------------------------------------------------------------------
package x86tlb_pkg;

  localparam int TLB_ENTRIES_DEF = 1024;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int IN_DATA_W       = 72;
  localparam int OUT_DATA_W      = 136;

  localparam logic [31:0] PG_A_BIT     = 32'h0000_0020;
  localparam logic [31:0] PG_D_BIT     = 32'h0000_0040;
  localparam logic [31:0] PG_AD_BITS   = 32'h0000_0060;
  localparam logic [31:0] PG_PS_BIT    = 32'h0000_0080;
  localparam logic [31:0] PG_BIG_MASK  = 32'hFFC0_0000;
  localparam logic [31:0] PG_MID_MASK  = 32'h003F_F000;
  localparam logic [31:0] PG_FRM_MASK  = 32'hFFFF_F000;

  typedef enum logic [2:0] {
    CFG_PAGING     = 3'd0,
    CFG_WP         = 3'd1,
    CFG_PSE        = 3'd2,
    CFG_DIR_BASE   = 3'd3,
    CFG_FRAME_MASK = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TRANSLATE  = 2'd0,
    OP_DATA       = 2'd1,
    OP_FLUSH_ALL  = 2'd2,
    OP_FLUSH_PAGE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_DONE  = 2'd0,
    K_FAULT = 2'd1,
    K_READ  = 2'd2,
    K_WRITE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DIR   = 2'd1,
    PH_TABLE = 2'd2,
    PH_DIRTY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BS_CLEAR = 2'd0,
    BS_IDLE  = 2'd1,
    BS_LOOK  = 2'd2,
    BS_OUT   = 2'd3
  } bstate_t;

  typedef struct packed {
    logic        paging;
    logic        wp;
    logic        pse;
    logic [19:0] dir_base;
    logic [31:0] frame_mask;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] lin;
    logic        is_write;
    logic        is_user;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [31:0] phys;
    logic [2:0]  code;
    logic [31:0] faddr;
  } res_t;

  typedef struct packed {
    logic [19:0] vpn;
    logic [19:0] frame;
    logic [31:0] ploc;
    logic [2:0]  rights;
  } ent_t;

  typedef struct packed {
    logic clearing;
  } bstat_t;

  function automatic res_t mk_res(kind_t k, logic [31:0] a, logic [31:0] wd,
                                  logic [31:0] ph, logic [2:0] c, logic [31:0] fa);
    res_t r;
    r.kind  = k;
    r.addr  = a;
    r.wdata = wd;
    r.phys  = ph;
    r.code  = c;
    r.faddr = fa;
    return r;
  endfunction

  // acc bit0 write, bit1 user
  function automatic logic refused(logic w, logic u, logic [1:0] acc, logic wp);
    logic r;
    r = 1'b0;
    if (acc[1] && !u) r = 1'b1;
    if (acc[0] && !w && (acc[1] || wp)) r = 1'b1;
    return r;
  endfunction

endpackage

FILE: rtl/core/x86_paging_mmu_tlb.sv
// ----------------------------------------------------------------------------
// x86_paging_mmu_tlb
// 32-bit linear address translation through a direct-mapped TLB with a
// two-level table walk carried out over the request/result streams.
//
//   port group  | dir | contents
//   in_*        | in  | tuser operation; tdata lin_addr, is_write, is_user, mem_data
//   out_*       | out | tuser kind; tlast last; tdata mem_addr .. fault_addr
//   cfg_*       | in  | register index and write data, write enable
//
// one request at a time in the back end: the first result passes the slot stage,
// the queue and, with paging on, the entry memory's registered read before it is
// offered, then one result per cycle while out_tready holds
// reset and flush all sweep the whole valid array; no requests are
// taken during the sweep
// a stalled output holds the back end; the front still takes up to three requests
// ----------------------------------------------------------------------------
module x86_paging_mmu_tlb #(
  parameter int TLB_ENTRIES = x86tlb_pkg::TLB_ENTRIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [1:0]                            in_tuser,  // operation
  // lin_addr, is_write, is_user, mem_data, zero pad
  input  logic [x86tlb_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [1:0]                            out_tuser, // kind
  output logic                                  out_tlast,
  // mem_addr, mem_wdata, phys_addr, fault_code, fault_addr, zero pad
  output logic [x86tlb_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                  cfg_we,
  input  logic [x86tlb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [x86tlb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import x86tlb_pkg::*;

  localparam int IDX_W = $clog2(TLB_ENTRIES);

  cfg_t             cfg_r;
  item_t            in_item;
  bstat_t           bstat;
  logic             q_valid, q_pop;
  item_t            q_item;
  logic [IDX_W-1:0] q_slot;
  res_t             out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.paging     <= 1'b0;
      cfg_r.wp         <= 1'b0;
      cfg_r.pse        <= 1'b0;
      cfg_r.dir_base   <= 20'd0;
      cfg_r.frame_mask <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_PAGING:     cfg_r.paging     <= cfg_wdata[0];
        CFG_WP:         cfg_r.wp         <= cfg_wdata[0];
        CFG_PSE:        cfg_r.pse        <= cfg_wdata[0];
        CFG_DIR_BASE:   cfg_r.dir_base   <= cfg_wdata[19:0];
        CFG_FRAME_MASK: cfg_r.frame_mask <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_item.op       = op_t'(in_tuser);
  assign in_item.lin      = in_tdata[31:0];
  assign in_item.is_write = in_tdata[32];
  assign in_item.is_user  = in_tdata[33];
  assign in_item.data     = in_tdata[65:34];

  x86tlb_front #(.TLB_ENTRIES(TLB_ENTRIES), .IDX_W(IDX_W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .bstat    (bstat),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_slot   (q_slot),
    .q_pop    (q_pop)
  );

  x86tlb_back #(.TLB_ENTRIES(TLB_ENTRIES), .IDX_W(IDX_W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_slot    (q_slot),
    .q_pop     (q_pop),
    .bstat     (bstat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_last  (out_tlast)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {5'd0, out_res.faddr, out_res.code, out_res.phys,
                      out_res.wdata, out_res.addr};

endmodule

FILE: rtl/core/x86tlb_front.sv
// ----------------------------------------------------------------------------
// x86tlb_front
// Accepts requests, works out the TLB slot and queues them for the back end.
// ----------------------------------------------------------------------------
module x86tlb_front #(
  parameter int TLB_ENTRIES = x86tlb_pkg::TLB_ENTRIES_DEF,
  parameter int IDX_W       = $clog2(TLB_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  x86tlb_pkg::item_t   in_item,
  input  x86tlb_pkg::bstat_t  bstat,
  output logic                q_valid,
  output x86tlb_pkg::item_t   q_item,
  output logic [IDX_W-1:0]    q_slot,
  input  logic                q_pop
);
  import x86tlb_pkg::*;

  localparam int          SH         = 20 + IDX_W;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'(TLB_ENTRIES) - 64'd1)
                                       / 64'(TLB_ENTRIES);
  localparam logic [21:0] RECIP      = RECIP_FULL[21:0];
  localparam logic [19:0] N20        = 20'(TLB_ENTRIES);

  logic        s1_valid_r, s1_valid_nxt;
  item_t       s1_item_r;
  logic [41:0] s1_prod_r;

  logic [19:0] quo;
  logic [39:0] qn;
  logic [19:0] rem_raw;
  logic [19:0] rem_fix;
  logic        push;

  item_t            fifo_item_r [2];
  logic [IDX_W-1:0] fifo_slot_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;

  assign in_ready = !s1_valid_r && !bstat.clearing;
  assign push     = s1_valid_r && (cnt_r != 2'd2);

  // slot = vpn mod entries, via reciprocal
  assign quo     = 20'(s1_prod_r >> SH);
  assign qn      = quo * N20;
  assign rem_raw = s1_item_r.lin[31:12] - qn[19:0];
  assign rem_fix = (rem_raw >= N20) ? rem_raw - N20 : rem_raw;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (push) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
      s1_prod_r <= in_item.lin[31:12] * RECIP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (q_pop) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_item_r[wptr_r] <= s1_item_r;
      fifo_slot_r[wptr_r] <= rem_fix[IDX_W-1:0];
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = fifo_item_r[rptr_r];
  assign q_slot  = fifo_slot_r[rptr_r];

endmodule

FILE: rtl/core/x86tlb_back.sv
// ----------------------------------------------------------------------------
// x86tlb_back
// TLB memory, lookup, table walk sequencing and result registers.
// ----------------------------------------------------------------------------
module x86tlb_back #(
  parameter int TLB_ENTRIES = x86tlb_pkg::TLB_ENTRIES_DEF,
  parameter int IDX_W       = $clog2(TLB_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  x86tlb_pkg::cfg_t    cfg,
  input  logic                q_valid,
  input  x86tlb_pkg::item_t   q_item,
  input  logic [IDX_W-1:0]    q_slot,
  output logic                q_pop,
  output x86tlb_pkg::bstat_t  bstat,
  output logic                out_valid,
  input  logic                out_ready,
  output x86tlb_pkg::res_t    out_res,
  output logic                out_last
);
  import x86tlb_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

  bstate_t state_r, state_nxt;
  phase_t  phase_r, phase_nxt;
  logic [31:0]      pend_lin_r, pend_lin_nxt;
  logic [1:0]       pend_acc_r, pend_acc_nxt;
  logic [IDX_W-1:0] pend_slot_r, pend_slot_nxt;
  logic [31:0]      held_pde_r, held_pde_nxt;
  logic [31:0]      held_loc_r, held_loc_nxt;
  logic [19:0]      hit_frame_r, hit_frame_nxt;
  logic [31:0]      hit_ploc_r, hit_ploc_nxt;
  logic [2:0]       hit_rights_r, hit_rights_nxt;
  res_t             res_r [3];
  res_t             res_nxt [3];
  logic [1:0]       res_cnt_r, res_cnt_nxt;
  logic [1:0]       res_idx_r, res_idx_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [1:0]       n_c;

  ent_t             dmem [TLB_ENTRIES];
  logic             vmem [TLB_ENTRIES];
  ent_t             rd_ent_r;
  logic             rd_valid_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             dw_en;
  ent_t             dw_data;
  logic             vw_en;
  logic [IDX_W-1:0] vw_addr;
  logic             vw_data;

  logic             fw_en;
  logic [31:0]      fw_entry, fw_loc, fw_base, fw_nent, fw_base_m, tbl_loc;
  logic             fw_w, fw_u;
  logic [31:0]      both;
  logic             hit;

  assign fw_nent   = fw_entry | PG_A_BIT | (pend_acc_r[0] ? PG_D_BIT : 32'd0);
  assign fw_base_m = fw_base & cfg.frame_mask;
  assign tbl_loc   = (held_pde_r & PG_FRM_MASK) + {20'd0, pend_lin_r[21:12], 2'b00};
  assign both      = held_pde_r & q_item.data;
  assign hit       = rd_valid_r && (rd_ent_r.vpn == pend_lin_r[31:12]);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    pend_lin_nxt   = pend_lin_r;
    pend_acc_nxt   = pend_acc_r;
    pend_slot_nxt  = pend_slot_r;
    held_pde_nxt   = held_pde_r;
    held_loc_nxt   = held_loc_r;
    hit_frame_nxt  = hit_frame_r;
    hit_ploc_nxt   = hit_ploc_r;
    hit_rights_nxt = hit_rights_r;
    res_nxt        = res_r;
    res_cnt_nxt    = res_cnt_r;
    res_idx_nxt    = res_idx_r;
    clr_nxt        = clr_r;
    n_c            = 2'd0;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = q_slot;
    dw_en          = 1'b0;
    dw_data        = '0;
    vw_en          = 1'b0;
    vw_addr        = pend_slot_r;
    vw_data        = 1'b0;
    fw_en          = 1'b0;
    fw_entry       = '0;
    fw_loc         = '0;
    fw_base        = '0;
    fw_w           = 1'b0;
    fw_u           = 1'b0;

    case (state_r)
      BS_CLEAR: begin
        vw_en   = 1'b1;
        vw_addr = clr_r;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == LAST_IDX) begin
          clr_nxt   = '0;
          state_nxt = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op)
            OP_FLUSH_ALL: state_nxt = BS_CLEAR;
            OP_FLUSH_PAGE: begin
              vw_en   = 1'b1;
              vw_addr = q_slot;
            end
            OP_TRANSLATE: begin
              if (phase_r == PH_IDLE) begin
                if (!cfg.paging) begin
                  res_nxt[n_c] = mk_res(K_DONE, '0, '0, q_item.lin, '0, '0);
                  n_c = n_c + 2'd1;
                end else begin
                  rd_en         = 1'b1;
                  pend_lin_nxt  = q_item.lin;
                  pend_acc_nxt  = {q_item.is_user, q_item.is_write};
                  pend_slot_nxt = q_slot;
                  state_nxt     = BS_LOOK;
                end
              end
            end
            OP_DATA: begin
              case (phase_r)
                PH_DIR: begin
                  phase_nxt    = PH_IDLE;
                  held_pde_nxt = q_item.data;
                  if (!q_item.data[0]) begin
                    vw_en = 1'b1;
                    res_nxt[n_c] = mk_res(K_FAULT, '0, '0, '0, {pend_acc_r, 1'b0},
                                          pend_lin_r);
                    n_c = n_c + 2'd1;
                  end else if (cfg.pse && ((q_item.data & PG_PS_BIT) != 32'd0)) begin
                    fw_en    = 1'b1;
                    fw_entry = q_item.data;
                    fw_loc   = held_loc_r;
                    fw_base  = (q_item.data & PG_BIG_MASK) | (pend_lin_r & PG_MID_MASK);
                    fw_w     = q_item.data[1];
                    fw_u     = q_item.data[2];
                  end else begin
                    phase_nxt = PH_TABLE;
                    res_nxt[n_c] = mk_res(K_READ, (q_item.data & PG_FRM_MASK)
                                   + {20'd0, pend_lin_r[21:12], 2'b00}, '0, '0, '0, '0);
                    n_c = n_c + 2'd1;
                  end
                end
                PH_TABLE: begin
                  phase_nxt = PH_IDLE;
                  if (!q_item.data[0]) begin
                    vw_en = 1'b1;
                    res_nxt[n_c] = mk_res(K_FAULT, '0, '0, '0, {pend_acc_r, 1'b0},
                                          pend_lin_r);
                    n_c = n_c + 2'd1;
                  end else begin
                    if (!held_pde_r[5]) begin
                      res_nxt[n_c] = mk_res(K_WRITE, held_loc_r, held_pde_r | PG_A_BIT,
                                            '0, '0, '0);
                      n_c = n_c + 2'd1;
                    end
                    fw_en    = 1'b1;
                    fw_entry = q_item.data;
                    fw_loc   = tbl_loc;
                    fw_base  = q_item.data & PG_FRM_MASK;
                    fw_w     = both[1];
                    fw_u     = both[2];
                  end
                end
                PH_DIRTY: begin
                  phase_nxt = PH_IDLE;
                  res_nxt[n_c] = mk_res(K_WRITE, hit_ploc_r, q_item.data | PG_AD_BITS,
                                        '0, '0, '0);
                  n_c = n_c + 2'd1;
                  dw_en   = 1'b1;
                  dw_data = '{vpn: pend_lin_r[31:12], frame: hit_frame_r,
                              ploc: hit_ploc_r, rights: hit_rights_r | 3'b100};
                  res_nxt[n_c] = mk_res(K_DONE, '0, '0, {hit_frame_r, pend_lin_r[11:0]},
                                        '0, '0);
                  n_c = n_c + 2'd1;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      BS_LOOK: begin
        if (hit) begin
          if (refused(rd_ent_r.rights[0], rd_ent_r.rights[1], pend_acc_r, cfg.wp)) begin
            res_nxt[n_c] = mk_res(K_FAULT, '0, '0, '0, {pend_acc_r, 1'b1}, pend_lin_r);
            n_c = n_c + 2'd1;
          end else if (pend_acc_r[0] && !rd_ent_r.rights[2]) begin
            phase_nxt      = PH_DIRTY;
            hit_frame_nxt  = rd_ent_r.frame;
            hit_ploc_nxt   = rd_ent_r.ploc;
            hit_rights_nxt = rd_ent_r.rights;
            res_nxt[n_c] = mk_res(K_READ, rd_ent_r.ploc, '0, '0, '0, '0);
            n_c = n_c + 2'd1;
          end else begin
            res_nxt[n_c] = mk_res(K_DONE, '0, '0, {rd_ent_r.frame, pend_lin_r[11:0]},
                                  '0, '0);
            n_c = n_c + 2'd1;
          end
        end else begin
          phase_nxt    = PH_DIR;
          held_loc_nxt = {cfg.dir_base, 12'd0} + {20'd0, pend_lin_r[31:22], 2'b00};
          res_nxt[n_c] = mk_res(K_READ, held_loc_nxt, '0, '0, '0, '0);
          n_c = n_c + 2'd1;
        end
        state_nxt = BS_IDLE;
      end
      BS_OUT: begin
        if (out_ready) begin
          if (res_idx_r == res_cnt_r - 2'd1) begin
            res_idx_nxt = 2'd0;
            state_nxt   = BS_IDLE;
          end else begin
            res_idx_nxt = res_idx_r + 2'd1;
          end
        end
      end
      default: state_nxt = BS_IDLE;
    endcase

    if (fw_en) begin
      vw_en = 1'b1;
      if (refused(fw_w, fw_u, pend_acc_r, cfg.wp)) begin
        res_nxt[n_c] = mk_res(K_FAULT, '0, '0, '0, {pend_acc_r, 1'b1}, pend_lin_r);
        n_c = n_c + 2'd1;
      end else begin
        if (fw_nent != fw_entry) begin
          res_nxt[n_c] = mk_res(K_WRITE, fw_loc, fw_nent, '0, '0, '0);
          n_c = n_c + 2'd1;
        end
        vw_data = 1'b1;
        dw_en   = 1'b1;
        dw_data = '{vpn: pend_lin_r[31:12], frame: fw_base_m[31:12], ploc: fw_loc,
                    rights: {fw_nent[6], fw_u, fw_w}};
        res_nxt[n_c] = mk_res(K_DONE, '0, '0, {fw_base_m[31:12], pend_lin_r[11:0]},
                              '0, '0);
        n_c = n_c + 2'd1;
      end
    end

    if ((state_r == BS_IDLE || state_r == BS_LOOK) && n_c != 2'd0) begin
      res_cnt_nxt = n_c;
      res_idx_nxt = 2'd0;
      state_nxt   = BS_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BS_CLEAR;
      phase_r   <= PH_IDLE;
      clr_r     <= '0;
      res_cnt_r <= 2'd0;
      res_idx_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      clr_r     <= clr_nxt;
      res_cnt_r <= res_cnt_nxt;
      res_idx_r <= res_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_lin_r   <= pend_lin_nxt;
    pend_acc_r   <= pend_acc_nxt;
    pend_slot_r  <= pend_slot_nxt;
    held_pde_r   <= held_pde_nxt;
    held_loc_r   <= held_loc_nxt;
    hit_frame_r  <= hit_frame_nxt;
    hit_ploc_r   <= hit_ploc_nxt;
    hit_rights_r <= hit_rights_nxt;
    res_r        <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (dw_en) dmem[pend_slot_r] <= dw_data;
    if (rd_en) rd_ent_r <= dmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vw_en) vmem[vw_addr] <= vw_data;
    if (rd_en) rd_valid_r <= vmem[rd_addr];
  end

  assign bstat.clearing = (state_r == BS_CLEAR);
  assign out_valid      = (state_r == BS_OUT);
  assign out_res        = res_r[res_idx_r];
  assign out_last       = (res_idx_r == res_cnt_r - 2'd1);

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (res_idx_r < res_cnt_r))
    else $error("result index past result count");

  a_look_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_LOOK) |-> ($past(state_r) == BS_IDLE))
    else $error("lookup not entered from idle");

  a_read_leaves_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && out_res.kind == K_READ) |-> (phase_r != PH_IDLE))
    else $error("read request issued without a walk in progress");
`endif

endmodule
